[rtl/assert_macros.svh]
// Assertion macros shared by the checker files of the rank unit.
// No dependencies; pulled in by `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a given clock and active-low reset.
`define RIRP_ASSERT(name, ck, rst_n, prop) \
	name: assert property (@(posedge ck) disable iff (!rst_n) prop) \
		else $error("rirp assertion failed");

// Same, on the block's own clk and arst_n.
`define RIRP_ASSERT_CLK(name, prop) \
	`RIRP_ASSERT(name, clk, arst_n, prop)

`endif

[rtl/rirp_pkg.sv]
// Package of the recency rank unit: sizes, operation codes, shared types.
// No dependencies; used by every module of the unit.
package rirp_pkg;

	localparam int WAYS   = 16;
	localparam int SETS   = 64;
	localparam int RANK_W = 4;
	localparam int WAY_W  = 4;
	localparam int SET_W  = 6;
	localparam int ROW_W  = RANK_W * WAYS;
	localparam int SET_AW = $clog2(SETS);

	typedef enum logic [1:0] {
		OP_TOUCH = 2'd0,
		OP_FILL  = 2'd1,
		OP_INVAL = 2'd2,
		OP_QUERY = 2'd3
	} op_t;

	typedef logic [ROW_W-1:0]  row_t;
	typedef logic [SET_AW-1:0] set_addr_t;

	// control of the rank memory
	typedef struct packed {
		logic      rd_en;
		set_addr_t rd_addr;
		logic      wr_en;
		set_addr_t wr_addr;
	} ram_req_t;

	// row after reset: way i holds rank i
	function automatic row_t reset_row();
		row_t r;
		r = '0;
		for (int i = 0; i < WAYS; i++) begin
			r[RANK_W*i +: RANK_W] = RANK_W'(i);
		end
		return r;
	endfunction

endpackage

[rtl/rirp_rank_ram.sv]
// Rank memory: one row of way ranks per set, registered read.
// Depends on rirp_pkg. Unwritten rows read as the reset order.
module rirp_rank_ram
	import rirp_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  ram_req_t req,
	input  row_t     wr_data,
	output row_t     rd_data
);

	row_t             mem [SETS];
	logic [SETS-1:0]  written_q;
	row_t             rd_row_q;
	logic             rd_written_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= wr_data;
		end
		if (req.rd_en) begin
			rd_row_q     <= mem[req.rd_addr];
			rd_written_q <= written_q[req.rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
		end else if (req.wr_en) begin
			written_q[req.wr_addr] <= 1'b1;
		end
	end

	assign rd_data = rd_written_q ? rd_row_q : reset_row();

endmodule

[rtl/rirp_update.sv]
// Rank update of one set row: moves a way to its target rank, shifts the
// ranks in between, and finds the least recent way. Depends on rirp_pkg.
module rirp_update
	import rirp_pkg::*;
(
	input  row_t              row,
	input  op_t               op,
	input  logic [WAY_W-1:0]  way,
	input  logic [RANK_W-1:0] insert_rank,
	output row_t              new_row,
	output logic [WAY_W-1:0]  victim
);

	localparam logic [RANK_W:0] MaxRank = (RANK_W+1)'(WAYS - 1);
	localparam logic [WAY_W:0]  WayLim  = (WAY_W+1)'(WAYS);

	logic [RANK_W-1:0] cur_rank;
	logic [RANK_W-1:0] tgt_rank;
	logic              do_move;

	always_comb begin
		case (op)
			OP_TOUCH: tgt_rank = MaxRank[RANK_W-1:0];
			OP_FILL:  tgt_rank = ({1'b0, insert_rank} > MaxRank) ?
				MaxRank[RANK_W-1:0] : insert_rank;
			default:  tgt_rank = '0;
		endcase
	end

	assign do_move  = (op != OP_QUERY) && ({1'b0, way} < WayLim);
	assign cur_rank = row[RANK_W*way +: RANK_W];

	always_comb begin
		logic [RANK_W-1:0] ri;
		new_row = row;
		for (int i = 0; i < WAYS; i++) begin
			ri = row[RANK_W*i +: RANK_W];
			if (do_move) begin
				if (WAY_W'(i) == way) begin
					new_row[RANK_W*i +: RANK_W] = tgt_rank;
				end else if (tgt_rank > cur_rank && ri > cur_rank && ri <= tgt_rank) begin
					new_row[RANK_W*i +: RANK_W] = ri - 1'b1;
				end else if (tgt_rank < cur_rank && ri >= tgt_rank && ri < cur_rank) begin
					new_row[RANK_W*i +: RANK_W] = ri + 1'b1;
				end
			end
		end
	end

	// lowest way holding rank 0
	always_comb begin
		victim = '0;
		for (int i = WAYS - 1; i >= 0; i--) begin
			if (new_row[RANK_W*i +: RANK_W] == '0) begin
				victim = WAY_W'(i);
			end
		end
	end

endmodule

[rtl/recency_insertion_replacement_unit.sv]
// Top level of the recency rank replacement unit.
// Depends on rirp_pkg, rirp_rank_ram and rirp_update.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one word per lookup:
//   operation (touch, fill, invalidate, victim query), set_index and way.
//   Output channel (out_valid / out_stall) returns one word per input
//   word: victim_way, the least recent way of the set after the update.
//   cfg_wr_en / cfg_wr_data write insert_rank, the rank a fill lands on.
// Timing:
//   The read stage reads the set row from the rank memory; the update
//   stage then updates the row, writes it back and loads the output
//   register. One word per cycle is sustained while out_stall is low;
//   the row written back is forwarded to the next read, so back-to-back
//   words to the same set see each other's update.
// Reset:
//   arst_n clears the pipeline, sets insert_rank to 8 and marks all rows
//   unwritten; an unwritten row reads as way i at rank i. No clearing pass.
// Stall:
//   While out_stall holds a pending result, one more word waits in the
//   read stage; further input is stalled until the output drains.
module recency_insertion_replacement_unit
	import rirp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// configuration
	input  logic              cfg_wr_en,
	input  logic [RANK_W-1:0] cfg_wr_data,
	// input words
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        operation,
	input  logic [SET_W-1:0]  set_index,
	input  logic [WAY_W-1:0]  way,
	// result words
	output logic              out_valid,
	input  logic              out_stall,
	output logic [WAY_W-1:0]  victim_way
);

	logic [RANK_W-1:0] insert_rank_q;

	// read stage
	logic              valid_s1;
	op_t               op_s1;
	set_addr_t         set_s1;
	logic [WAY_W-1:0]  way_s1;

	// last row written, for same-set forwarding
	logic              fwd_valid_q;
	set_addr_t         fwd_set_q;
	row_t              fwd_row_q;

	logic              out_valid_q;
	logic [WAY_W-1:0]  victim_way_q;

	ram_req_t          ram_req;
	row_t              rd_row;
	row_t              cur_row;
	row_t              upd_row;
	logic [WAY_W-1:0]  upd_victim;
	logic              out_free;
	logic              adv_s1;
	logic              in_acc;
	set_addr_t         in_set;

	assign out_free = !out_valid_q || !out_stall;
	assign adv_s1   = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign in_acc   = in_valid && !in_stall;
	// set count is a power of two: modulo is the low bits
	assign in_set   = set_index[SET_AW-1:0];

	assign ram_req.rd_en   = in_acc;
	assign ram_req.rd_addr = in_set;
	assign ram_req.wr_en   = adv_s1;
	assign ram_req.wr_addr = set_s1;

	rirp_rank_ram u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (ram_req),
		.wr_data (upd_row),
		.rd_data (rd_row)
	);

	// newest copy of the row: a write in the same edge as the read is missed
	// by the memory, so take it from the forward register
	assign cur_row = (fwd_valid_q && fwd_set_q == set_s1) ? fwd_row_q : rd_row;

	rirp_update u_upd (
		.row         (cur_row),
		.op          (op_s1),
		.way         (way_s1),
		.insert_rank (insert_rank_q),
		.new_row     (upd_row),
		.victim      (upd_victim)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			insert_rank_q <= RANK_W'(8);
			valid_s1      <= 1'b0;
			fwd_valid_q   <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				insert_rank_q <= cfg_wr_data;
			end
			if (in_acc) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				fwd_valid_q <= 1'b1;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_s1  <= op_t'(operation);
			set_s1 <= in_set;
			way_s1 <= way;
		end
		if (adv_s1) begin
			fwd_set_q    <= set_s1;
			fwd_row_q    <= upd_row;
			victim_way_q <= upd_victim;
		end
	end

	assign out_valid  = out_valid_q;
	assign victim_way = victim_way_q;

endmodule

[rtl/rirp_checker.sv]
// Port-level checks of the recency rank unit, bound to its top level.
// Depends on assert_macros.svh and rirp_pkg.
`include "assert_macros.svh"

module rirp_checker
	import rirp_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_stall,
	input logic             out_valid,
	input logic             out_stall,
	input logic [WAY_W-1:0] victim_way
);

	// held result stays put
	`RIRP_ASSERT_CLK(a_out_hold, out_valid && out_stall |=> out_valid && $stable(victim_way))
	// input backs up only behind a stalled pending result
	`RIRP_ASSERT_CLK(a_stall_cause, in_stall |-> out_valid && out_stall)
	// a fresh result follows an accepted word
	`RIRP_ASSERT_CLK(a_out_latency, $rose(out_valid) |-> $past(in_valid && !in_stall, 2))

endmodule

bind recency_insertion_replacement_unit rirp_checker u_rirp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.victim_way (victim_way)
);
